// ===== design/gclcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gclcr_pkg
// shared types and constants of the command line checksum receiver
// ----------------------------------------------------------------------------
package gclcr_pkg;

    localparam int LINE_NUMBER_WIDTH = 16;
    localparam int NUM_W             = LINE_NUMBER_WIDTH;
    localparam int OUT_NUM_W         = 16;

    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_N        = 8'h4E;
    localparam logic [7:0] CH_M        = 8'h4D;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] LIMIT_RESET = 8'd100;

    localparam logic [NUM_W-1:0] MC_STANDBY    = NUM_W'(1);
    localparam logic [NUM_W-1:0] MC_MOTORS_ON  = NUM_W'(17);
    localparam logic [NUM_W-1:0] MC_MOTORS_OFF = NUM_W'(18);
    localparam logic [NUM_W-1:0] MC_REPEAT     = NUM_W'(41);
    localparam logic [NUM_W-1:0] MC_POSITION   = NUM_W'(114);
    localparam logic [NUM_W-1:0] MC_VERSION    = NUM_W'(115);

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_NUMBERED = 4'b0010,
        MODE_MCODE    = 4'b0100,
        MODE_OTHER    = 4'b1000
    } mode_t;

    typedef enum logic [2:0] {
        STAR_BEFORE = 3'b001,
        STAR_HIGH   = 3'b010,
        STAR_LOW    = 3'b100
    } star_t;

    typedef enum logic [2:0] {
        VERDICT_NONE = 3'b001,
        VERDICT_PASS = 3'b010,
        VERDICT_FAIL = 3'b100
    } verdict_t;

    typedef enum logic [3:0] {
        EV_ACK        = 4'd0,
        EV_QUIET      = 4'd1,
        EV_RESEND     = 4'd2,
        EV_STANDBY    = 4'd3,
        EV_MOTORS_ON  = 4'd4,
        EV_MOTORS_OFF = 4'd5,
        EV_REPEAT     = 4'd6,
        EV_POSITION   = 4'd7,
        EV_VERSION    = 4'd8,
        EV_UNKNOWN    = 4'd9
    } event_code_t;

    typedef struct packed {
        event_code_t                ev_code;
        logic [OUT_NUM_W-1:0]       line_number;
        logic [OUT_NUM_W-1:0]       program_length;
    } result_t;

endpackage

// ===== design/gclcr_in_stage.sv =====
// ----------------------------------------------------------------------------
// gclcr_in_stage
// input register for received bytes, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module gclcr_in_stage
    import gclcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       s_fire;

    assign s_ready    = !valid_reg || advance;
    assign s_fire     = s_valid && s_ready;
    assign valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

// ===== design/gclcr_parser.sv =====
// ----------------------------------------------------------------------------
// gclcr_parser
// line framing, checksum, number parsing and event decision for one item
// ----------------------------------------------------------------------------
module gclcr_parser
    import gclcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_data,
    input  logic       advance,
    input  logic [7:0] item_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam int SAT_W = NUM_W + 4;

    logic [7:0]           limit_reg;
    mode_t                mode_reg,    mode_next;
    logic [7:0]           count_reg,   count_next;
    logic [7:0]           xor_reg,     xor_next;
    star_t                star_reg,    star_next;
    verdict_t             verdict_reg, verdict_next;
    logic                 run_reg,     run_next;
    logic                 seen_reg,    seen_next;
    logic [NUM_W-1:0]     acc_reg,     acc_next;
    logic [OUT_NUM_W-1:0] good_reg,    good_next;
    logic [OUT_NUM_W-1:0] pc_reg,      pc_next;

    logic                 is_digit;
    logic                 is_end;
    logic [SAT_W-1:0]     acc_wide_mul;
    logic [NUM_W-1:0]     acc_digit;
    logic [31:0]          acc_wide;
    logic [OUT_NUM_W-1:0] num16;
    logic [OUT_NUM_W-1:0] cap16;
    event_code_t          mcode_ev;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'h0, nib};
        return (nib < 4'd10) ? (CH_ZERO + n8) : (CH_LOWER_A + n8 - 8'd10);
    endfunction

    assign is_digit     = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);
    assign is_end       = (item_byte == CH_CR) || (item_byte == CH_LF);
    assign acc_wide_mul = SAT_W'(acc_reg) * SAT_W'(10) + SAT_W'(item_byte - CH_ZERO);
    assign acc_digit    = (acc_wide_mul > SAT_W'({NUM_W{1'b1}})) ? {NUM_W{1'b1}}
                                                                   : acc_wide_mul[NUM_W-1:0];
    assign acc_wide     = 32'(acc_reg);
    assign num16        = acc_wide[OUT_NUM_W-1:0];
    assign cap16        = (acc_wide > 32'(16'hFFFF)) ? 16'hFFFF : num16;

    always_comb begin
        if (!seen_reg) begin
            mcode_ev = EV_UNKNOWN;
        end else begin
            unique case (acc_reg)
                MC_STANDBY:    mcode_ev = EV_STANDBY;
                MC_MOTORS_ON:  mcode_ev = EV_MOTORS_ON;
                MC_MOTORS_OFF: mcode_ev = EV_MOTORS_OFF;
                MC_REPEAT:     mcode_ev = EV_REPEAT;
                MC_POSITION:   mcode_ev = EV_POSITION;
                MC_VERSION:    mcode_ev = EV_VERSION;
                default:       mcode_ev = EV_UNKNOWN;
            endcase
        end
    end

    // next state and event for the byte in the input register
    always_comb begin
        mode_next    = mode_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        star_next    = star_reg;
        verdict_next = verdict_reg;
        run_next     = run_reg;
        seen_next    = seen_reg;
        acc_next     = acc_reg;
        good_next    = good_reg;
        pc_next      = pc_reg;
        res_valid    = 1'b0;
        res.ev_code     = EV_UNKNOWN;
        res.line_number = '0;

        unique case (mode_reg)
            MODE_IDLE: begin
                if (item_byte == CH_N) begin
                    mode_next = MODE_NUMBERED;
                end else if (item_byte == CH_M) begin
                    mode_next = MODE_MCODE;
                end else begin
                    mode_next = MODE_OTHER;
                end
                count_next   = 8'd1;
                xor_next     = CH_N;
                star_next    = STAR_BEFORE;
                verdict_next = VERDICT_NONE;
                run_next     = 1'b1;
                seen_next    = 1'b0;
                acc_next     = '0;
            end
            MODE_NUMBERED: begin
                if (!is_end && (count_reg < limit_reg)) begin
                    count_next = count_reg + 8'd1;
                    // checksum
                    if (verdict_reg == VERDICT_NONE) begin
                        unique case (star_reg)
                            STAR_BEFORE: begin
                                if (item_byte == CH_NUL) begin
                                    verdict_next = VERDICT_FAIL;
                                end else if (item_byte == CH_STAR) begin
                                    star_next = STAR_HIGH;
                                end else begin
                                    xor_next = xor_reg ^ item_byte;
                                end
                            end
                            STAR_HIGH: begin
                                if (item_byte == hex_char(xor_reg[7:4])) begin
                                    star_next = STAR_LOW;
                                end else begin
                                    verdict_next = VERDICT_FAIL;
                                end
                            end
                            STAR_LOW: begin
                                verdict_next = (item_byte == hex_char(xor_reg[3:0]))
                                               ? VERDICT_PASS : VERDICT_FAIL;
                            end
                            default: begin
                                verdict_next = VERDICT_FAIL;
                            end
                        endcase
                    end
                    // line number digits
                    if (run_reg) begin
                        if (is_digit) begin
                            acc_next  = acc_digit;
                            seen_next = 1'b1;
                        end else begin
                            run_next = 1'b0;
                        end
                    end
                end else begin
                    mode_next = MODE_IDLE;
                    res_valid = 1'b1;
                    if (verdict_reg != VERDICT_PASS) begin
                        res.ev_code     = EV_RESEND;
                        res.line_number = good_reg;
                    end else if (!seen_reg) begin
                        res.ev_code = EV_UNKNOWN;
                    end else begin
                        good_next       = num16;
                        res.line_number = num16;
                        if (item_byte == CH_CR) begin
                            pc_next     = cap16;
                            res.ev_code = EV_ACK;
                        end else begin
                            if ((item_byte == CH_LF) && (pc_reg < cap16)) begin
                                pc_next = cap16;
                            end
                            res.ev_code = EV_QUIET;
                        end
                    end
                end
            end
            MODE_MCODE, MODE_OTHER: begin
                if (item_byte != CH_CR) begin
                    if ((mode_reg == MODE_MCODE) && run_reg) begin
                        if (is_digit) begin
                            acc_next  = acc_digit;
                            seen_next = 1'b1;
                        end else begin
                            run_next = 1'b0;
                        end
                    end
                end else begin
                    mode_next   = MODE_IDLE;
                    res_valid   = 1'b1;
                    res.ev_code = (mode_reg == MODE_MCODE) ? mcode_ev : EV_UNKNOWN;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
        res.program_length = pc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RESET;
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            xor_reg     <= '0;
            star_reg    <= STAR_BEFORE;
            verdict_reg <= VERDICT_NONE;
            run_reg     <= 1'b1;
            seen_reg    <= 1'b0;
            acc_reg     <= '0;
            good_reg    <= '0;
            pc_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (advance) begin
                mode_reg    <= mode_next;
                count_reg   <= count_next;
                xor_reg     <= xor_next;
                star_reg    <= star_next;
                verdict_reg <= verdict_next;
                run_reg     <= run_next;
                seen_reg    <= seen_next;
                acc_reg     <= acc_next;
                good_reg    <= good_next;
                pc_reg      <= pc_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (mode_reg != MODE_IDLE))
        else $error("result from a byte that opens a line");

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |=> (mode_reg == MODE_IDLE))
        else $error("line not closed after its result");

    a_pass_after_low_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (verdict_reg == VERDICT_PASS) |-> (star_reg == STAR_LOW))
        else $error("checksum passed before both hex digits");

    a_length_drops_only_on_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !(res_valid && (res.ev_code == EV_ACK))) |=> (pc_reg >= $past(pc_reg)))
        else $error("program length dropped without an ack");
`endif

endmodule

// ===== design/gclcr_out_stage.sv =====
// ----------------------------------------------------------------------------
// gclcr_out_stage
// result register holding one event until the receiver takes it
// ----------------------------------------------------------------------------
module gclcr_out_stage
    import gclcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              res,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_event_res,
    output logic [OUT_NUM_W-1:0] m_line_number,
    output logic [OUT_NUM_W-1:0] m_program_length
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid          = valid_reg;
    assign m_event_res      = res_reg.ev_code;
    assign m_line_number    = res_reg.line_number;
    assign m_program_length = res_reg.program_length;

endmodule

// ===== design/gcode_line_checksum_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// gcode_line_checksum_receiver_unit
// frames received command bytes into lines and reports line events
// ----------------------------------------------------------------------------
// s_ channel: one received byte per item. m_ channel: one event item per
// completed line (ok, quiet ok, resend or an m-code class) with the line
// number and the program length after the event. cfg_ channel: writes the
// numbered line length limit; cfg_ready is always high, write only when idle.
// A byte waits in the input register and is processed from there into the
// result register, which raises m_valid for the byte that ends a line. Both
// registers refill in the cycle they drain, so one byte per cycle is taken
// while the result side keeps up; the line state update between them sets
// that rate.
// A stalled receiver holds the result register; bytes that produce no event
// keep flowing, and the input stops only when a byte that would produce an
// event meets a full result register.
// Reset clears the line state, last good line number and program length,
// and returns the limit to 100.
// ----------------------------------------------------------------------------
module gcode_line_checksum_receiver_unit
    import gclcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_event_res,
    output logic [OUT_NUM_W-1:0] m_line_number,
    output logic [OUT_NUM_W-1:0] m_program_length
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       advance;
    logic       res_valid;
    result_t    res;

    assign cfg_ready = 1'b1;

    // an item without an event never waits on the result side
    assign advance = item_valid && (!m_valid || m_ready || !res_valid);

    gclcr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    gclcr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item_byte (item_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    gclcr_out_stage u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (advance && res_valid),
        .res              (res),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_line_number    (m_line_number),
        .m_program_length (m_program_length)
    );

endmodule
